>>> design/mact_pkg.sv
// ---------------------------------------------------------------------------
// mact_pkg : shared types and constants of the crossover trader
// Field widths, derived datapath widths, payload structs and unit op codes.
// ---------------------------------------------------------------------------
package mact_pkg;

   // History depth and price width
   localparam int HIST_DEPTH = 256;
   localparam int PRICE_W    = 24;

   // Fixed field widths
   localparam int CASH_W = 48;
   localparam int WIN_W  = 9;
   localparam int ACT_W  = 2;
   localparam int IDX_W  = 2;

   // Derived widths
   localparam int ADDR_W  = $clog2(HIST_DEPTH);
   localparam int SEEN_W  = $clog2(HIST_DEPTH + 1);
   localparam int SUM_W   = PRICE_W + $clog2(HIST_DEPTH);
   localparam int LHS_W   = SUM_W + WIN_W;
   localparam int MPL_W   = (PRICE_W > WIN_W) ? PRICE_W : WIN_W;
   localparam int ALU_W   = CASH_W + PRICE_W;
   localparam int CNT_MAX = (HIST_DEPTH > CASH_W) ? HIST_DEPTH : CASH_W;
   localparam int CNT_W   = $clog2(CNT_MAX + 1);

   localparam logic [CASH_W-1:0] CASH_MAX = {CASH_W{1'b1}};

   // Register reset values
   localparam logic [WIN_W-1:0]  SHORT_WIN_RST = WIN_W'(50);
   localparam logic [WIN_W-1:0]  LONG_WIN_RST  = WIN_W'(200);
   localparam logic [CASH_W-1:0] CAPITAL_RST   = CASH_W'(1000000);

   // Register indexes
   localparam logic [IDX_W-1:0] CSR_SHORT_WIN = IDX_W'(0);
   localparam logic [IDX_W-1:0] CSR_LONG_WIN  = IDX_W'(1);
   localparam logic [IDX_W-1:0] CSR_CAPITAL   = IDX_W'(2);

   typedef enum logic [ACT_W-1:0] {
      ACT_NONE,
      ACT_BUY,
      ACT_SELL,
      ACT_CLOSE
   } action_type;

   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic               final_price;
   } req_type;

   typedef struct packed {
      action_type         action;
      logic [CASH_W-1:0]  share_count;
      logic [PRICE_W-1:0] trade_price;
      logic [CASH_W-1:0]  cash_after;
      logic               run_end;
   } rsp_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      logic             carry;
      logic             zero;
      logic [ALU_W-1:0] y;
   } alu_res_type;

endpackage

>>> design/mact_ram.sv
// ---------------------------------------------------------------------------
// mact_ram : generic single write, single read memory
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module mact_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/mact_alu.sv
// ---------------------------------------------------------------------------
// mact_alu : shared add/subtract unit
// Wide adder used for sums, product steps, division steps and compares.
// ---------------------------------------------------------------------------
module mact_alu import mact_pkg::*; (
   input  alu_op_type       op,
   input  logic [ALU_W-1:0] a,
   input  logic [ALU_W-1:0] b,
   output alu_res_type      res
);

   logic [ALU_W:0] wide;

   always_comb begin
      unique case (op)
         ALU_ADD: wide = {1'b0, a} + {1'b0, b};
         ALU_SUB: wide = {1'b0, a} - {1'b0, b};
      endcase
   end

   // carry is the carry out on add, the borrow on subtract
   assign res.carry = wide[ALU_W];
   assign res.y     = wide[ALU_W-1:0];
   assign res.zero  = (wide[ALU_W-1:0] == '0);

endmodule

>>> design/moving_average_crossover_trader.sv
// ---------------------------------------------------------------------------
// moving_average_crossover_trader : dual moving average crossover trader
// Takes closing prices, compares short and long averages of earlier prices,
// buys, sells and closes positions, and reports each trade.
// ---------------------------------------------------------------------------
//
// Channel   Ports                                    Direction  Moves
// req       req_valid req_ready req_data             in         one price
// rsp       rsp_valid rsp_ready rsp_data             out        one trade report
// csr       csr_valid csr_ready csr_index csr_wdata  in         one register write
//
// Sequence: an item seen before the long window is filled is only written to
// the history. Afterwards the L newest earlier prices (L = effective long
// window) are read back through the single memory read port, then come two
// 24-step products and one compare. A buy adds a division (48 quotient bits,
// one per cycle, then the update and the report), a sell or final close a
// product (24 multiplier bits, the cash update and the report). A final price
// ends the run in a finishing state, after an empty report when nothing traded.
// Reset: synchronous; control and trading registers take their reset values;
// no clearing pass is needed since history is read only once written in a run.
// Stalls: a report waits in its state while the output register holds an
// untaken transfer; the next price is accepted as soon as the block is idle.
//
module moving_average_crossover_trader import mact_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [CASH_W-1:0] csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SUM,
      S_MUL,
      S_CMP,
      S_DIV,
      S_BUY,
      S_ADDV,
      S_EMIT,
      S_WRITE,
      S_FINISH
   } state_type;

   typedef enum logic [1:0] {
      JOB_LHS,
      JOB_RHS,
      JOB_SELL,
      JOB_CLOSE
   } job_type;

   // Sequencer and configuration
   state_type           state_ff, state_in;
   state_type           ret_ff, ret_in;
   job_type             job_ff, job_in;
   logic [WIN_W-1:0]    short_win_ff, short_win_in;
   logic [WIN_W-1:0]    long_win_ff, long_win_in;
   logic [CASH_W-1:0]   capital_ff, capital_in;

   // Trading state
   logic [PRICE_W-1:0]  price_ff, price_in;
   logic                final_ff, final_in;
   logic [CASH_W-1:0]   cash_ff, cash_in;
   logic [CASH_W-1:0]   held_ff, held_in;
   logic                holding_ff, holding_in;
   logic [SEEN_W-1:0]   seen_ff, seen_in;
   logic [ADDR_W-1:0]   ptr_ff, ptr_in;
   logic                emitted_ff, emitted_in;

   // History read-back
   logic [ADDR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [SEEN_W-1:0]   iss_ff, iss_in;
   logic                rd_vld_ff, rd_vld_in;

   // Shared datapath registers
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [ALU_W-1:0]    acc_ff, acc_in;
   logic [CASH_W-1:0]   mcand_ff, mcand_in;
   logic [MPL_W-1:0]    mplier_ff, mplier_in;
   logic [SUM_W-1:0]    long_sum_ff, long_sum_in;
   logic [LHS_W-1:0]    lhs_ff, lhs_in;

   // Pending report and output register
   action_type          pend_act_ff, pend_act_in;
   logic [CASH_W-1:0]   pend_shares_ff, pend_shares_in;
   logic                pend_end_ff, pend_end_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   // Combinational helpers
   logic [WIN_W-1:0]    lw_eff;
   logic [WIN_W-1:0]    sw_eff;
   logic [ADDR_W-1:0]   ptr_prev;
   logic [ADDR_W-1:0]   ptr_next;
   logic [ADDR_W-1:0]   rd_ptr_prev;
   logic [CASH_W-1:0]   value_sat;
   logic                out_free;
   logic                ram_rd_en;
   logic                ram_wr_en;
   logic [PRICE_W-1:0]  ram_rdata;
   alu_op_type          alu_op;
   logic [ALU_W-1:0]    alu_a;
   logic [ALU_W-1:0]    alu_b;
   alu_res_type         alu_res;

   mact_ram #(
      .WIDTH (PRICE_W),
      .DEPTH (HIST_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ptr_ff),
      .wr_data (price_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rdata)
   );

   mact_alu u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .res (alu_res)
   );

   // Clamp the windows: long to 1 .. depth, short to 1 .. long
   always_comb begin
      lw_eff = long_win_ff;
      if (long_win_ff == '0) begin
         lw_eff = WIN_W'(1);
      end else if (long_win_ff > HIST_DEPTH) begin
         lw_eff = WIN_W'(HIST_DEPTH);
      end
      sw_eff = short_win_ff;
      if (short_win_ff == '0) begin
         sw_eff = WIN_W'(1);
      end else if (short_win_ff > lw_eff) begin
         sw_eff = lw_eff;
      end
   end

   // Circular pointer steps
   assign ptr_prev    = (ptr_ff == '0) ? ADDR_W'(HIST_DEPTH - 1) : ptr_ff - 1'b1;
   assign ptr_next    = (ptr_ff == ADDR_W'(HIST_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
   assign rd_ptr_prev = (rd_ptr_ff == '0) ? ADDR_W'(HIST_DEPTH - 1) : rd_ptr_ff - 1'b1;

   // Trade value saturates at full cash width
   assign value_sat = (acc_ff[ALU_W-1:CASH_W] != '0) ? CASH_MAX : acc_ff[CASH_W-1:0];

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in       = state_ff;
      ret_in         = ret_ff;
      job_in         = job_ff;
      short_win_in   = short_win_ff;
      long_win_in    = long_win_ff;
      capital_in     = capital_ff;
      price_in       = price_ff;
      final_in       = final_ff;
      cash_in        = cash_ff;
      held_in        = held_ff;
      holding_in     = holding_ff;
      seen_in        = seen_ff;
      ptr_in         = ptr_ff;
      emitted_in     = emitted_ff;
      rd_ptr_in      = rd_ptr_ff;
      iss_in         = iss_ff;
      cnt_in         = cnt_ff;
      acc_in         = acc_ff;
      mcand_in       = mcand_ff;
      mplier_in      = mplier_ff;
      long_sum_in    = long_sum_ff;
      lhs_in         = lhs_ff;
      pend_act_in    = pend_act_ff;
      pend_shares_in = pend_shares_ff;
      pend_end_in    = pend_end_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      ram_rd_en      = 1'b0;
      ram_wr_en      = 1'b0;
      alu_op         = ALU_ADD;
      alu_a          = '0;
      alu_b          = '0;

      // Register writes must arrive only while idle; the block does not enforce it
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SHORT_WIN: short_win_in = csr_wdata[WIN_W-1:0];
            CSR_LONG_WIN:  long_win_in  = csr_wdata[WIN_W-1:0];
            CSR_CAPITAL:   capital_in   = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               price_in   = req_data.price;
               final_in   = req_data.final_price;
               emitted_in = 1'b0;
               // new run: load starting cash, drop any position
               if (seen_ff == '0) begin
                  cash_in    = capital_ff;
                  held_in    = '0;
                  holding_in = 1'b0;
               end
               if (seen_ff >= lw_eff) begin
                  rd_ptr_in = ptr_prev;
                  iss_in    = '0;
                  cnt_in    = '0;
                  acc_in    = '0;
                  state_in  = S_SUM;
               end else begin
                  state_in = S_WRITE;
               end
            end
         end

         S_SUM: begin
            // issue one read per cycle, newest price first
            if (iss_ff < lw_eff) begin
               ram_rd_en = 1'b1;
               rd_ptr_in = rd_ptr_prev;
               iss_in    = iss_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               alu_a  = acc_ff;
               alu_b  = ALU_W'(ram_rdata);
               acc_in = alu_res.y;
               cnt_in = cnt_ff + 1'b1;
               // short sum is a prefix of the long sum: snapshot it
               if (cnt_ff == CNT_W'(sw_eff - 1'b1)) begin
                  mcand_in = CASH_W'(alu_res.y[SUM_W-1:0]);
               end
               if (cnt_ff == CNT_W'(lw_eff - 1'b1)) begin
                  long_sum_in = alu_res.y[SUM_W-1:0];
                  mplier_in   = MPL_W'(lw_eff);
                  acc_in      = '0;
                  cnt_in      = '0;
                  job_in      = JOB_LHS;
                  state_in    = S_MUL;
               end
            end
         end

         S_MUL: begin
            // shift-add product, multiplier MSB first
            alu_a     = {acc_ff[ALU_W-2:0], 1'b0};
            alu_b     = mplier_ff[MPL_W-1] ? ALU_W'(mcand_ff) : '0;
            acc_in    = alu_res.y;
            mplier_in = {mplier_ff[MPL_W-2:0], 1'b0};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MPL_W - 1)) begin
               cnt_in = '0;
               unique case (job_ff)
                  JOB_LHS: begin
                     lhs_in    = alu_res.y[LHS_W-1:0];
                     mcand_in  = CASH_W'(long_sum_ff);
                     mplier_in = MPL_W'(sw_eff);
                     acc_in    = '0;
                     job_in    = JOB_RHS;
                  end
                  JOB_RHS: begin
                     state_in = S_CMP;
                  end
                  JOB_SELL, JOB_CLOSE: begin
                     state_in = S_ADDV;
                  end
               endcase
            end
         end

         S_CMP: begin
            // short_sum * L against long_sum * S
            alu_op = ALU_SUB;
            alu_a  = ALU_W'(lhs_ff);
            alu_b  = acc_ff;
            priority if (!holding_ff && !alu_res.carry && !alu_res.zero
                         && price_ff != '0) begin
               acc_in   = '0;
               mcand_in = cash_ff;
               cnt_in   = '0;
               state_in = S_DIV;
            end else if (holding_ff && alu_res.carry) begin
               mcand_in  = held_ff;
               mplier_in = MPL_W'(price_ff);
               acc_in    = '0;
               cnt_in    = '0;
               job_in    = JOB_SELL;
               state_in  = S_MUL;
            end else begin
               state_in = S_WRITE;
            end
         end

         S_DIV: begin
            // restoring division: remainder in acc, quotient shifts into mcand
            alu_op   = ALU_SUB;
            alu_a    = ALU_W'({acc_ff[PRICE_W-1:0], mcand_ff[CASH_W-1]});
            alu_b    = ALU_W'(price_ff);
            acc_in   = alu_res.carry ? alu_a : alu_res.y;
            mcand_in = {mcand_ff[CASH_W-2:0], !alu_res.carry};
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CASH_W - 1)) begin
               state_in = S_BUY;
            end
         end

         S_BUY: begin
            // remainder is the cash left after paying for the shares
            cash_in        = acc_ff[CASH_W-1:0];
            held_in        = mcand_ff;
            holding_in     = 1'b1;
            pend_act_in    = ACT_BUY;
            pend_shares_in = mcand_ff;
            pend_end_in    = final_ff && (mcand_ff == '0);
            emitted_in     = 1'b1;
            ret_in         = S_WRITE;
            state_in       = S_EMIT;
         end

         S_ADDV: begin
            alu_a          = ALU_W'(cash_ff);
            alu_b          = ALU_W'(value_sat);
            cash_in        = alu_res.y[CASH_W] ? CASH_MAX : alu_res.y[CASH_W-1:0];
            pend_shares_in = held_ff;
            emitted_in     = 1'b1;
            state_in       = S_EMIT;
            if (job_ff == JOB_SELL) begin
               pend_act_in = ACT_SELL;
               pend_end_in = final_ff;
               held_in     = '0;
               holding_in  = 1'b0;
               ret_in      = S_WRITE;
            end else begin
               pend_act_in = ACT_CLOSE;
               pend_end_in = 1'b1;
               ret_in      = S_FINISH;
            end
         end

         S_EMIT: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.action      = pend_act_ff;
               rsp_in.share_count = pend_shares_ff;
               rsp_in.trade_price = price_ff;
               rsp_in.cash_after  = cash_ff;
               rsp_in.run_end     = pend_end_ff;
               state_in           = ret_ff;
            end
         end

         S_WRITE: begin
            ram_wr_en = 1'b1;
            ptr_in    = ptr_next;
            if (seen_ff < SEEN_W'(HIST_DEPTH)) begin
               seen_in = seen_ff + 1'b1;
            end
            if (!final_ff) begin
               state_in = S_IDLE;
            end else begin
               priority if (holding_ff && held_ff != '0) begin
                  mcand_in  = held_ff;
                  mplier_in = MPL_W'(price_ff);
                  acc_in    = '0;
                  cnt_in    = '0;
                  job_in    = JOB_CLOSE;
                  state_in  = S_MUL;
               end else if (!emitted_ff) begin
                  pend_act_in    = ACT_NONE;
                  pend_shares_in = '0;
                  pend_end_in    = 1'b1;
                  ret_in         = S_FINISH;
                  state_in       = S_EMIT;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end

         S_FINISH: begin
            // end of run: drop position, restart the history
            held_in    = '0;
            holding_in = 1'b0;
            seen_in    = '0;
            ptr_in     = '0;
            state_in   = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rd_vld_in = ram_rd_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         short_win_ff <= SHORT_WIN_RST;
         long_win_ff  <= LONG_WIN_RST;
         capital_ff   <= CAPITAL_RST;
         cash_ff      <= CAPITAL_RST;
         held_ff      <= '0;
         holding_ff   <= 1'b0;
         seen_ff      <= '0;
         ptr_ff       <= '0;
         emitted_ff   <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         short_win_ff <= short_win_in;
         long_win_ff  <= long_win_in;
         capital_ff   <= capital_in;
         cash_ff      <= cash_in;
         held_ff      <= held_in;
         holding_ff   <= holding_in;
         seen_ff      <= seen_in;
         ptr_ff       <= ptr_in;
         emitted_ff   <= emitted_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ret_ff         <= ret_in;
      job_ff         <= job_in;
      price_ff       <= price_in;
      final_ff       <= final_in;
      rd_ptr_ff      <= rd_ptr_in;
      iss_ff         <= iss_in;
      cnt_ff         <= cnt_in;
      acc_ff         <= acc_in;
      mcand_ff       <= mcand_in;
      mplier_ff      <= mplier_in;
      long_sum_ff    <= long_sum_in;
      lhs_ff         <= lhs_in;
      pend_act_ff    <= pend_act_in;
      pend_shares_ff <= pend_shares_in;
      pend_end_ff    <= pend_end_in;
      rsp_ff         <= rsp_in;
   end

   // No position means no shares held
   a_flat_no_shares: assert property (@(posedge clock) disable iff (reset)
      !holding_ff |-> (held_ff == '0))
      else $error("shares held while flat");

   // Division remainder stays below the divisor
   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (acc_ff < ALU_W'(price_ff)))
      else $error("division remainder not below price");

   // A report waiting on a free output register is loaded next cycle
   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("pending report not loaded");

endmodule
